// ===== rtl/tlbpt_pkg.sv =====
// Shared constants for the TLB and page table address translator.
// Holds default sizes and the stream data widths; depends on nothing else.
`default_nettype none

package tlbpt_pkg;

    // Default sizes handed to the top level parameters.
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 8;

    // Address widths fixed by the item fields.
    localparam int VA_W = 16;
    localparam int PA_W = 16;

    // Result item: physical address, hit flag, fault flag, padded to bytes.
    localparam int RES_W       = PA_W + 2;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;

endpackage

`default_nettype wire

// ===== rtl/tlb_page_table_translator.sv =====
// Top level of the address translator: FIFO-replaced TLB in front of a
// demand-paged page table. Depends on tlbpt_pkg for defaults and widths.
`default_nettype none

// How to use this block:
// The slave stream carries one virtual address per item. Its upper bits are
// the page number and its low OFFSET_BITS bits the offset. The master stream
// returns one result item per address: the physical address, a flag that the
// page was found in the TLB, and a flag that the page was unmapped and was
// just given the next free frame.
// The address is registered together with a read of the page table memory,
// then the TLB compare, the page table update and the TLB fill all happen in
// one pass into the output register.
// Throughput is one item per cycle while the master stream takes results.
// The page table memory has a single read port, read once per accepted address.
// A stalled master stream holds the output register; the stage ahead of it
// still takes one more address if it is empty, and then s_axis_tready falls.
// Reset empties the pipeline, marks every page invalid, empties the TLB and
// restarts frame numbering at zero. Frame contents are not reset, since a
// frame is only read after it has been written.
// PAGE_COUNT is expected to be a power of two.
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: virtual_address[15:0].
    input  wire logic [VA_W-1:0]        s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0: physical_address[15:0], tlb_hit, page_fault, zero pad.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int PB   = $clog2(PAGE_COUNT);
    localparam int TI   = $clog2(TLB_ENTRIES);
    localparam int FC_W = $clog2(TLB_ENTRIES + 1);
    localparam int NF_W = $clog2(PAGE_COUNT + 1);

    // Input handshake and address split.
    logic                   in_fire;
    logic [2*VA_W-1:0]      in_va_ext;
    logic [2*VA_W-1:0]      in_vpn_wide;
    logic [PB-1:0]          in_page;

    // First stage: registered address and page table read.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [PB-1:0]          s1_page_reg;
    logic [OFFSET_BITS-1:0] s1_offset_reg;
    logic [PB-1:0]          pt_rd_reg;
    logic                   byp_hit_reg;
    logic [PB-1:0]          byp_frame_reg;
    logic                   s1_move;

    // Page table.
    logic [PB-1:0]          pt_frame_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0]  page_vld_reg;
    logic [PAGE_COUNT-1:0]  page_vld_next;
    logic [NF_W-1:0]        next_frame_reg;
    logic [NF_W-1:0]        next_frame_next;
    logic                   pt_wr_en;

    // TLB.
    logic [PB-1:0]          tlb_tag_reg   [TLB_ENTRIES];
    logic [PB-1:0]          tlb_frame_reg [TLB_ENTRIES];
    logic [FC_W-1:0]        tlb_fill_reg;
    logic [FC_W-1:0]        tlb_fill_next;
    logic [TI-1:0]          tlb_oldest_reg;
    logic [TI-1:0]          tlb_oldest_next;
    logic                   tlb_full;
    logic [TI-1:0]          ins_slot;

    // Lookup results of the first stage.
    logic                   s1_hit;
    logic [PB-1:0]          s1_hit_frame;
    logic                   s1_fault;
    logic [PB-1:0]          new_frame;
    logic [PB-1:0]          table_frame;
    logic [PB-1:0]          s1_frame;
    logic [PB+OFFSET_BITS+PA_W-1:0] pa_wide;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PA_W-1:0]        out_pa_reg;
    logic                   out_hit_reg;
    logic                   out_fault_reg;

    // ------------------------------------------------------------------
    // Handshakes. The first stage moves on whenever the output register is
    // empty or is being drained, and a new address enters behind it.
    // ------------------------------------------------------------------
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1
                                    : ((out_valid_reg && m_axis_tready) ? 1'b0 : out_valid_reg);

    // The page number is the address above the offset, masked to the table.
    assign in_va_ext   = {{VA_W{1'b0}}, s_axis_tdata};
    assign in_vpn_wide = in_va_ext >> OFFSET_BITS;
    assign in_page     = in_vpn_wide[PB-1:0];

    // ------------------------------------------------------------------
    // TLB compare over all filled entries. Tags are unique among filled
    // entries since a page is only inserted after a miss.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_hit       = 1'b0;
        s1_hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if ((FC_W'(i) < tlb_fill_reg) && (tlb_tag_reg[i] == s1_page_reg))
            begin
                s1_hit       = 1'b1;
                s1_hit_frame = tlb_frame_reg[i];
            end
        end
    end

    // A frame written by the previous item in the same cycle as this item's
    // table read is taken from the bypass register instead of the memory.
    assign table_frame = byp_hit_reg ? byp_frame_reg : pt_rd_reg;
    assign new_frame   = next_frame_reg[PB-1:0];
    assign s1_fault    = !s1_hit && !page_vld_reg[s1_page_reg];
    assign s1_frame    = s1_hit ? s1_hit_frame : (s1_fault ? new_frame : table_frame);
    assign pa_wide     = {{PA_W{1'b0}}, s1_frame, s1_offset_reg};
    assign pt_wr_en    = s1_move && s1_fault;

    // Fill in order, then overwrite the oldest entry.
    assign tlb_full = (tlb_fill_reg == FC_W'(TLB_ENTRIES));
    assign ins_slot = tlb_full ? tlb_oldest_reg : tlb_fill_reg[TI-1:0];

    always_comb
    begin
        tlb_fill_next   = tlb_fill_reg;
        tlb_oldest_next = tlb_oldest_reg;
        page_vld_next   = page_vld_reg;
        next_frame_next = next_frame_reg;
        if (s1_move && !s1_hit)
        begin
            if (!tlb_full)
            begin
                tlb_fill_next = tlb_fill_reg + FC_W'(1);
            end
            else if (tlb_oldest_reg == TI'(TLB_ENTRIES - 1))
            begin
                tlb_oldest_next = '0;
            end
            else
            begin
                tlb_oldest_next = tlb_oldest_reg + TI'(1);
            end
        end
        if (pt_wr_en)
        begin
            page_vld_next[s1_page_reg] = 1'b1;
            if (next_frame_reg < NF_W'(PAGE_COUNT))
            begin
                next_frame_next = next_frame_reg + NF_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tlb_fill_reg   <= '0;
            tlb_oldest_reg <= '0;
            page_vld_reg   <= '0;
            next_frame_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            tlb_fill_reg   <= tlb_fill_next;
            tlb_oldest_reg <= tlb_oldest_next;
            page_vld_reg   <= page_vld_next;
            next_frame_reg <= next_frame_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers, TLB storage and the page table memory.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_page_reg   <= in_page;
            s1_offset_reg <= s_axis_tdata[OFFSET_BITS-1:0];
            pt_rd_reg     <= pt_frame_mem[in_page];
            byp_hit_reg   <= pt_wr_en && (s1_page_reg == in_page);
            byp_frame_reg <= new_frame;
        end
        if (pt_wr_en)
        begin
            pt_frame_mem[s1_page_reg] <= new_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && !s1_hit)
        begin
            tlb_tag_reg[ins_slot]   <= s1_page_reg;
            tlb_frame_reg[ins_slot] <= s1_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pa_reg    <= pa_wide[PA_W-1:0];
            out_hit_reg   <= s1_hit;
            out_fault_reg <= s1_fault;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_fault_reg, out_hit_reg, out_pa_reg};

`ifndef SYNTH
    a_hit_excludes_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_fault_reg))
        else $error("hit and fault flagged on the same result");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tlb_fill_reg <= FC_W'(TLB_ENTRIES))
        else $error("TLB fill count past capacity");

    a_oldest_idle_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tlb_full |-> (tlb_oldest_reg == '0))
        else $error("replacement pointer moved before the TLB filled");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_frame_reg <= NF_W'(PAGE_COUNT))
        else $error("free frame counter past the page count");

    a_fault_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pt_wr_en |=> page_vld_reg[$past(s1_page_reg)])
        else $error("faulted page not marked valid");

    a_hit_page_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit) |-> page_vld_reg[s1_page_reg])
        else $error("TLB hit on a page the table holds invalid");
`endif

endmodule

`default_nettype wire
